// ===== hdl/cda_pkg.sv =====
// Shared types, constants and microcode store for the calendar date adder.
// Used by cda_ctrl, cda_datapath and the top level; depends on nothing.
package cda_pkg;

	// operation codes of an input beat
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DAYS   = 2'd1,
		OP_MONTHS = 2'd2,
		OP_YEARS  = 2'd3
	} op_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LEAPQ,   // year / 100 into the quotient register
		DP_MLEN,    // month length into the length register
		DP_ADDY,    // year += amount
		DP_FEB29,   // Feb 29 -> Mar 1 in a common year
		DP_MTOT,    // amount += month - 1
		DP_MDIV,    // total / 12 into the quotient register
		DP_MAPPLY,  // apply quotient and remainder to year and month
		DP_CLAMP,   // clamp day to month length
		DP_NEXTM,   // step to first day of next month
		DP_ADDD     // day += remaining count
	} dp_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_BAD_YM,
		C_BAD_DAY,
		C_OVF,
		C_N_ZERO,
		C_FITS,
		C_NOT_DEC
	} cond_t;

	localparam int UPC_W = 5;
	typedef logic [UPC_W-1:0] upc_t;

	// one control word
	typedef struct packed {
		dp_op_t dp_op;
		cond_t  cond;
		upc_t   target;
		logic   commit;
		logic   finish;
		logic   err;
	} cw_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic   accept;
		op_t    op;
		dp_op_t dp_op;
		logic   commit;
	} cda_ctl_t;

	// status flags from datapath to sequencer
	typedef struct packed {
		logic bad_ym;
		logic bad_day;
		logic ovf;
		logic n_zero;
		logic fits;
		logic not_dec;
	} cda_flags_t;

	// program addresses
	localparam upc_t A_COMMIT = 5'd0;
	localparam upc_t A_ERR    = 5'd1;
	localparam upc_t A_LOAD   = 5'd2;
	localparam upc_t A_YEARS  = 5'd6;
	localparam upc_t A_MONTHS = 5'd9;
	localparam upc_t A_DAYS   = 5'd15;
	localparam upc_t A_DLEN   = 5'd16;
	localparam upc_t A_DFIN   = 5'd21;

	// reset date
	localparam logic [13:0] RST_YEAR  = 14'd2001;
	localparam logic [3:0]  RST_MONTH = 4'd1;
	localparam logic [4:0]  RST_DAY   = 5'd1;

	// reciprocals: y/100 exact for y < 43699, t/12 exact for t < 2^17
	localparam logic [13:0] RECIP_100 = 14'd5243;
	localparam logic [15:0] RECIP_12  = 16'd43691;
	localparam int          RECIP_SH  = 19;

	function automatic upc_t entry(op_t op);
		upc_t a;
		unique case (op)
			OP_LOAD:   a = A_LOAD;
			OP_DAYS:   a = A_DAYS;
			OP_MONTHS: a = A_MONTHS;
			OP_YEARS:  a = A_YEARS;
		endcase
		return a;
	endfunction

	function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic cw_t mk(dp_op_t o, cond_t c, upc_t t, logic cm, logic fi, logic er);
		cw_t w;
		w.dp_op  = o;
		w.cond   = c;
		w.target = t;
		w.commit = cm;
		w.finish = fi;
		w.err    = er;
		return w;
	endfunction

	// microcode store
	function automatic cw_t ucode(upc_t a);
		cw_t w;
		unique case (a)
			// common exits
			5'd0:  w = mk(DP_NOP,    C_NEVER,   A_COMMIT, 1'b1, 1'b1, 1'b0);
			5'd1:  w = mk(DP_NOP,    C_NEVER,   A_ERR,    1'b0, 1'b1, 1'b1);
			// load
			5'd2:  w = mk(DP_LEAPQ,  C_BAD_YM,  A_ERR,    1'b0, 1'b0, 1'b0);
			5'd3:  w = mk(DP_MLEN,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd4:  w = mk(DP_NOP,    C_BAD_DAY, A_ERR,    1'b0, 1'b0, 1'b0);
			5'd5:  w = mk(DP_NOP,    C_ALWAYS,  A_COMMIT, 1'b0, 1'b0, 1'b0);
			// add years
			5'd6:  w = mk(DP_ADDY,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd7:  w = mk(DP_LEAPQ,  C_OVF,     A_ERR,    1'b0, 1'b0, 1'b0);
			5'd8:  w = mk(DP_FEB29,  C_ALWAYS,  A_COMMIT, 1'b0, 1'b0, 1'b0);
			// add months
			5'd9:  w = mk(DP_MTOT,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd10: w = mk(DP_MDIV,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd11: w = mk(DP_MAPPLY, C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd12: w = mk(DP_LEAPQ,  C_OVF,     A_ERR,    1'b0, 1'b0, 1'b0);
			5'd13: w = mk(DP_MLEN,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd14: w = mk(DP_CLAMP,  C_ALWAYS,  A_COMMIT, 1'b0, 1'b0, 1'b0);
			// add days: one month per pass
			5'd15: w = mk(DP_LEAPQ,  C_N_ZERO,  A_COMMIT, 1'b0, 1'b0, 1'b0);
			5'd16: w = mk(DP_MLEN,   C_NEVER,   A_ERR,    1'b0, 1'b0, 1'b0);
			5'd17: w = mk(DP_NOP,    C_FITS,    A_DFIN,   1'b0, 1'b0, 1'b0);
			5'd18: w = mk(DP_NEXTM,  C_NOT_DEC, A_DLEN,   1'b0, 1'b0, 1'b0);
			5'd19: w = mk(DP_LEAPQ,  C_OVF,     A_ERR,    1'b0, 1'b0, 1'b0);
			5'd20: w = mk(DP_NOP,    C_ALWAYS,  A_DLEN,   1'b0, 1'b0, 1'b0);
			5'd21: w = mk(DP_ADDD,   C_ALWAYS,  A_COMMIT, 1'b0, 1'b0, 1'b0);
			default: w = mk(DP_NOP,  C_ALWAYS,  A_ERR,    1'b0, 1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/calendar_date_adder.sv =====
// Gregorian date adder, top level: sequencer plus date datapath.
// Depends on cda_pkg, cda_ctrl and cda_datapath.
//
// Holds one date (reset to 2001-01-01) and applies one command per beat.
// A command beat is taken when start is high and busy is low; op selects
// load, add days, add months or add years, with amount and the load_* fields.
// busy rises the cycle after a beat is taken and stays high while the
// microcode runs. The result beat (year, month, day, error) is marked by
// done for exactly one cycle, the first cycle with busy low again; the
// receiver cannot stall it and the next command may be taken in that same cycle,
// so commands follow one per latency + 1 cycles at best.
// Cycles from accept to done: load 5 (2 or 4 when rejected), add years 4,
// add months 7, add days 2 for a zero amount, else 5 + 3 per month crossed
// + 2 per year crossed (about 6800 at the largest amount); a year overflow
// ends the sequence early. The figure is set by the month-by-month loop of
// the control program, one datapath step per cycle.
// error is 1 for an invalid load or a year beyond MAX_YEAR; the date is kept.
// Asynchronous reset restores the reset date and leaves the block idle.
module calendar_date_adder #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] amount,
	input  logic [13:0] load_year,
	input  logic [3:0]  load_month,
	input  logic [4:0]  load_day,
	output logic        done,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic        error
);

	cda_pkg::cda_ctl_t   ctl;
	cda_pkg::cda_flags_t flags;

	// sequencer
	cda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (cda_pkg::op_t'(op)),
		.flags  (flags),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done),
		.error  (error)
	);

	// datapath
	cda_datapath #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.amount     (amount),
		.load_year  (load_year),
		.load_month (load_month),
		.load_day   (load_day),
		.flags      (flags),
		.year       (year),
		.month      (month),
		.day        (day)
	);

endmodule

// ===== hdl/cda_ctrl.sv =====
// Microcode sequencer: step counter, control store read and conditional jumps.
// Depends on cda_pkg.
module cda_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  cda_pkg::op_t          op,
	input  cda_pkg::cda_flags_t   flags,
	output cda_pkg::cda_ctl_t     ctl,
	output logic                  busy,
	output logic                  done,
	output logic                  error
);

	cda_pkg::upc_t pc_q;
	logic          busy_q;
	logic          done_q;
	logic          err_q;
	cda_pkg::cw_t  cw;
	logic          accept;
	logic          taken;

	assign accept = start && !busy_q;
	assign cw     = cda_pkg::ucode(pc_q);

	// jump condition select
	always_comb begin
		unique case (cw.cond)
			cda_pkg::C_NEVER:   taken = 1'b0;
			cda_pkg::C_ALWAYS:  taken = 1'b1;
			cda_pkg::C_BAD_YM:  taken = flags.bad_ym;
			cda_pkg::C_BAD_DAY: taken = flags.bad_day;
			cda_pkg::C_OVF:     taken = flags.ovf;
			cda_pkg::C_N_ZERO:  taken = flags.n_zero;
			cda_pkg::C_FITS:    taken = flags.fits;
			cda_pkg::C_NOT_DEC: taken = flags.not_dec;
		endcase
	end

	// datapath control, idle when not sequencing
	always_comb begin
		ctl.accept = accept;
		ctl.op     = op;
		ctl.dp_op  = busy_q ? cw.dp_op : cda_pkg::DP_NOP;
		ctl.commit = busy_q && cw.commit;
	end

	// step counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= cda_pkg::A_COMMIT;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			err_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				pc_q   <= cda_pkg::entry(op);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cw.finish) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					err_q  <= cw.err;
				end else if (taken) begin
					pc_q <= cw.target;
				end else begin
					pc_q <= pc_q + cda_pkg::upc_t'(1);
				end
			end
		end
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign error = err_q;

	// result beat always closes a sequence
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("result strobe while busy");

	// a finish step yields exactly one strobe
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cw.finish |=> done_q && !busy_q) else $error("finish without result");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !done_q) else $error("accepted beat not sequenced");

endmodule

// ===== hdl/cda_datapath.sv =====
// Date datapath: stored date, working registers, leap and month-length logic.
// Depends on cda_pkg; driven by cda_ctrl control words.
module cda_datapath #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cda_pkg::cda_ctl_t   ctl,
	input  logic [15:0]         amount,
	input  logic [13:0]         load_year,
	input  logic [3:0]          load_month,
	input  logic [4:0]          load_day,
	output cda_pkg::cda_flags_t flags,
	output logic [13:0]         year,
	output logic [3:0]          month,
	output logic [4:0]          day
);

	localparam logic [16:0] MAX_Y = 17'(MAX_YEAR);

	// stored date
	logic [13:0] cur_year_q;
	logic [3:0]  cur_month_q;
	logic [4:0]  cur_day_q;
	// working registers
	logic [16:0] wy_q;
	logic [3:0]  wm_q;
	logic [4:0]  wd_q;
	logic [16:0] n_q;
	logic [12:0] q_q;
	logic [4:0]  len_q;

	logic [27:0] prod100;
	logic [32:0] prod12;
	logic [19:0] q100;
	logic [16:0] q12;
	logic [16:0] rem12;
	logic        leap;
	logic [4:0]  left;

	// reciprocal products
	assign prod100 = {14'd0, wy_q[13:0]} * {14'd0, cda_pkg::RECIP_100};
	assign prod12  = {16'd0, n_q} * {17'd0, cda_pkg::RECIP_12};

	// leap rule from the registered quotient year / 100
	assign q100 = {7'd0, q_q} * 20'd100;
	assign leap = (wy_q[1:0] == 2'd0) &&
	              (({6'd0, wy_q[13:0]} != q100) || (q_q[1:0] == 2'd0));

	assign q12   = {4'd0, q_q} * 17'd12;
	assign rem12 = n_q - q12;
	assign left  = (len_q > wd_q) ? (len_q - wd_q) : 5'd0;

	// status for jumps
	always_comb begin
		flags.ovf     = wy_q > MAX_Y;
		flags.bad_ym  = (wy_q == 17'd0) || flags.ovf || (wm_q == 4'd0) || (wm_q > 4'd12);
		flags.bad_day = (wd_q == 5'd0) || (wd_q > len_q);
		flags.n_zero  = n_q == 17'd0;
		flags.fits    = n_q <= {12'd0, left};
		flags.not_dec = wm_q != 4'd12;
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			n_q <= {1'b0, amount};
			if (ctl.op == cda_pkg::OP_LOAD) begin
				wy_q <= {3'd0, load_year};
				wm_q <= load_month;
				wd_q <= load_day;
			end else begin
				wy_q <= {3'd0, cur_year_q};
				wm_q <= cur_month_q;
				wd_q <= cur_day_q;
			end
		end else begin
			unique case (ctl.dp_op)
				cda_pkg::DP_NOP: begin
				end
				cda_pkg::DP_LEAPQ: begin
					q_q <= {4'd0, prod100[cda_pkg::RECIP_SH +: 9]};
				end
				cda_pkg::DP_MLEN: begin
					len_q <= cda_pkg::month_len(wm_q, leap);
				end
				cda_pkg::DP_ADDY: begin
					wy_q <= wy_q + n_q;
				end
				cda_pkg::DP_FEB29: begin
					if (wm_q == 4'd2 && wd_q == 5'd29 && !leap) begin
						wm_q <= 4'd3;
						wd_q <= 5'd1;
					end
				end
				cda_pkg::DP_MTOT: begin
					n_q <= n_q + {13'd0, wm_q} - 17'd1;
				end
				cda_pkg::DP_MDIV: begin
					q_q <= prod12[cda_pkg::RECIP_SH +: 13];
				end
				cda_pkg::DP_MAPPLY: begin
					wy_q <= wy_q + {4'd0, q_q};
					wm_q <= rem12[3:0] + 4'd1;
				end
				cda_pkg::DP_CLAMP: begin
					if (wd_q > len_q) wd_q <= len_q;
				end
				cda_pkg::DP_NEXTM: begin
					n_q  <= n_q - {12'd0, left} - 17'd1;
					wd_q <= 5'd1;
					if (wm_q == 4'd12) begin
						wm_q <= 4'd1;
						wy_q <= wy_q + 17'd1;
					end else begin
						wm_q <= wm_q + 4'd1;
					end
				end
				cda_pkg::DP_ADDD: begin
					wd_q <= wd_q + n_q[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stored date, written on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= cda_pkg::RST_YEAR;
			cur_month_q <= cda_pkg::RST_MONTH;
			cur_day_q   <= cda_pkg::RST_DAY;
		end else if (ctl.commit) begin
			cur_year_q  <= wy_q[13:0];
			cur_month_q <= wm_q;
			cur_day_q   <= wd_q;
		end
	end

	assign year  = cur_year_q;
	assign month = cur_month_q;
	assign day   = cur_day_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for calendar_date_adder: directed table, then random commands.
// Depends on cda_pkg and calendar_date_adder; untyped results are checked against a local date model.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_YEAR     = 9999;
	localparam int RANDOM_ITEMS = 700;
	localparam int QUIET_LIMIT  = 50000;
	localparam int TAIL_CYCLES  = 20;

	typedef struct {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        error;
	} date_beat_t;

	typedef struct {
		cda_pkg::op_t op;
		logic [15:0]  amount;
		logic [13:0]  ly;
		logic [3:0]   lm;
		logic [4:0]   ld;
		bit           fixed;  // expected beat typed in the table
		date_beat_t   want;
	} cmd_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	cda_pkg::op_t cmd_op = cda_pkg::OP_LOAD;
	logic [15:0]  cmd_amount = '0;
	logic [13:0]  cmd_year = '0;
	logic [3:0]   cmd_month = '0;
	logic [4:0]   cmd_day = '0;
	logic         done;
	logic [13:0]  year;
	logic [3:0]   month;
	logic [4:0]   day;
	logic         error;

	// typed expectation travelling with the command beat
	bit          item_fixed = 1'b0;
	date_beat_t  item_want = '{default: '0};

	// model state of the stored date
	int unsigned cal_year = 2001;
	int unsigned cal_month = 1;
	int unsigned cal_day = 1;

	date_beat_t  pending_dates[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          burst_left = 0;
	cmd_row_t    directed[$];

	calendar_date_adder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (cmd_op),
		.amount     (cmd_amount),
		.load_year  (cmd_year),
		.load_month (cmd_month),
		.load_day   (cmd_day),
		.done       (done),
		.year       (year),
		.month      (month),
		.day        (day),
		.error      (error)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Gregorian leap rule
	function automatic bit leap_year(int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned y, int unsigned m);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// apply one command to the model date, return the beat it should produce
	function automatic date_beat_t apply_command(cda_pkg::op_t op, int unsigned n,
			int unsigned ly, int unsigned lm, int unsigned ld);
		date_beat_t  res;
		int unsigned y, m, d, len, left, total;
		bit          ok;
		ok = 1'b1;
		y = cal_year;
		m = cal_month;
		d = cal_day;
		case (op)
			cda_pkg::OP_LOAD: begin
				if (ly < 1 || ly > MAX_YEAR || lm < 1 || lm > 12 || ld < 1 ||
						ld > month_days(ly, lm))
					ok = 1'b0;
				else begin
					y = ly;
					m = lm;
					d = ld;
				end
			end
			cda_pkg::OP_DAYS: begin
				// one month per pass, as the count runs down
				while (n > 0) begin
					len = month_days(y, m);
					left = (len > d) ? len - d : 0;
					if (n <= left) begin
						d += n;
						n = 0;
					end else begin
						n -= left + 1;
						d = 1;
						m++;
						if (m > 12) begin
							m = 1;
							y++;
							if (y > MAX_YEAR) begin
								ok = 1'b0;
								n = 0;
							end
						end
					end
				end
			end
			cda_pkg::OP_MONTHS: begin
				total = (m - 1) + n;
				y = y + total / 12;
				m = total % 12 + 1;
				if (y > MAX_YEAR)
					ok = 1'b0;
				else begin
					len = month_days(y, m);
					if (d > len)
						d = len;
				end
			end
			default: begin
				y = y + n;
				if (y > MAX_YEAR)
					ok = 1'b0;
				else if (m == 2 && d == 29 && !leap_year(y)) begin
					m = 3;
					d = 1;
				end
			end
		endcase
		if (ok) begin
			cal_year = y;
			cal_month = m;
			cal_day = d;
		end
		res.year  = cal_year[13:0];
		res.month = cal_month[3:0];
		res.day   = cal_day[4:0];
		res.error = !ok;
		return res;
	endfunction

	function automatic cmd_row_t make_row(cda_pkg::op_t op, int unsigned amt, int unsigned ly,
			int unsigned lm, int unsigned ld, bit fixed, int unsigned wy, int unsigned wm,
			int unsigned wd, bit we);
		cmd_row_t r;
		r.op         = op;
		r.amount     = amt[15:0];
		r.ly         = ly[13:0];
		r.lm         = lm[3:0];
		r.ld         = ld[4:0];
		r.fixed      = fixed;
		r.want.year  = wy[13:0];
		r.want.month = wm[3:0];
		r.want.day   = wd[4:0];
		r.want.error = we;
		return r;
	endfunction

	// random command, mostly well-formed loads and modest amounts
	function automatic cmd_row_t random_row();
		cmd_row_t    r;
		int unsigned pick, y, m, len;
		r = make_row(cda_pkg::OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 16383),
			$urandom_range(0, 15), $urandom_range(0, 31), 1'b0, 0, 0, 0, 1'b0);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			if ($urandom_range(0, 9) != 0) begin
				case ($urandom_range(0, 3))
					0, 1:    y = $urandom_range(1, MAX_YEAR);
					2:       y = $urandom_range(1, 99) * 100;
					default: y = $urandom_range(MAX_YEAR - 10, MAX_YEAR);
				endcase
				m = $urandom_range(1, 12);
				len = month_days(y, m);
				r.ly = y[13:0];
				r.lm = m[3:0];
				r.ld = ($urandom_range(0, 2) == 0) ? len[4:0] : 5'($urandom_range(1, len));
			end
		end else if (pick < 55) begin
			r.op = cda_pkg::OP_DAYS;
			pick = $urandom_range(0, 99);
			if (pick < 90)
				r.amount = $urandom_range(0, 400);
			else if (pick < 97)
				r.amount = $urandom_range(0, 3000);
		end else if (pick < 80) begin
			r.op = cda_pkg::OP_MONTHS;
			if ($urandom_range(0, 99) < 85)
				r.amount = $urandom_range(0, 40);
		end else begin
			r.op = cda_pkg::OP_YEARS;
			pick = $urandom_range(0, 99);
			if (pick < 85)
				r.amount = $urandom_range(0, 30);
			else if (pick < 95)
				r.amount = $urandom_range(0, 2000);
		end
		return r;
	endfunction

	// drive one command beat and wait until it is taken
	task automatic issue_command(input cmd_row_t row);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			if ($urandom_range(0, 19) == 0)
				burst_left = $urandom_range(10, 40);
			gap = $urandom_range(0, 17);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		cmd_op     <= row.op;
		cmd_amount <= row.amount;
		cmd_year   <= row.ly;
		cmd_month  <= row.lm;
		cmd_day    <= row.ld;
		item_fixed <= row.fixed;
		item_want  <= row.want;
		do @(posedge clk); while (busy);
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result beats against expectations; command beats into the model
	always @(posedge clk) begin
		date_beat_t want;
		date_beat_t pred;
		if (arst_n) begin
			if (done) begin
				if (pending_dates.size() == 0) begin
					$error("result beat with no command waiting");
					mismatches++;
				end else begin
					want = pending_dates.pop_front();
					check_field("year", want.year, year);
					check_field("month", want.month, month);
					check_field("day", want.day, day);
					check_field("error", want.error, error);
				end
			end
			if (start && !busy) begin
				pred = apply_command(cmd_op, cmd_amount, cmd_year, cmd_month, cmd_day);
				pending_dates.push_back(item_fixed ? item_want : pred);
			end
			// watchdog on cycles with no beat either way
			if (done || (start && !busy))
				quiet_cycles = 0;
			else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("calendar_date_adder: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		// after reset, invalid loads, year overflow, leap day handling, extremes
		directed.push_back(make_row(cda_pkg::OP_DAYS,       0,     0,  0,  0, 1, 2001,  1,  1, 0));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2000,  2, 29, 1, 2000,  2, 29, 0));
		directed.push_back(make_row(cda_pkg::OP_YEARS,      1,     0,  0,  0, 1, 2001,  3,  1, 0));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  1900,  2, 29, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,     0,  5,  5, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2010,  0,  1, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2010, 13,  1, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,   65535,  2010, 15, 31, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2010,  4, 31, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2010,  6,  0, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0, 16383,  1,  1, 1, 2001,  3,  1, 1));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  9999, 12, 31, 1, 9999, 12, 31, 0));
		directed.push_back(make_row(cda_pkg::OP_DAYS,       1,     0,  0,  0, 1, 9999, 12, 31, 1));
		directed.push_back(make_row(cda_pkg::OP_MONTHS,     1,     0,  0,  0, 1, 9999, 12, 31, 1));
		directed.push_back(make_row(cda_pkg::OP_YEARS,      1,     0,  0,  0, 1, 9999, 12, 31, 1));
		directed.push_back(make_row(cda_pkg::OP_YEARS,      0,     0,  0,  0, 1, 9999, 12, 31, 0));
		directed.push_back(make_row(cda_pkg::OP_MONTHS,     0,     0,  0,  0, 1, 9999, 12, 31, 0));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2004,  1, 31, 1, 2004,  1, 31, 0));
		directed.push_back(make_row(cda_pkg::OP_MONTHS,     1,     0,  0,  0, 1, 2004,  2, 29, 0));
		directed.push_back(make_row(cda_pkg::OP_MONTHS,    13,     0,  0,  0, 1, 2005,  3, 29, 0));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,  2000, 12, 31, 1, 2000, 12, 31, 0));
		directed.push_back(make_row(cda_pkg::OP_DAYS,       1,     0,  0,  0, 1, 2001,  1,  1, 0));
		directed.push_back(make_row(cda_pkg::OP_LOAD,       0,     1,  1,  1, 1,    1,  1,  1, 0));
		directed.push_back(make_row(cda_pkg::OP_DAYS,   65535,     0,  0,  0, 0,    0,  0,  0, 0));
		directed.push_back(make_row(cda_pkg::OP_MONTHS, 65535,     0,  0,  0, 0,    0,  0,  0, 0));
		directed.push_back(make_row(cda_pkg::OP_YEARS,  65535,     0,  0,  0, 0,    0,  0,  0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			issue_command(directed[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue_command(random_row());
		start <= 1'b0;

		// drain, then a short tail for any stray result beat
		@(posedge clk);
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_dates.size() == 0)
			$display("calendar_date_adder: match");
		else
			$display("calendar_date_adder: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cda_pkg.sv
hdl/cda_ctrl.sv
hdl/cda_datapath.sv
hdl/calendar_date_adder.sv
sim/testbench.sv
